// File: design/q64sa_pkg.sv
// Shared types and constants for the unsigned 64.64 saturating ALU.
// Holds the command codes, the operand word and the result word layout.
// No dependencies.
package q64sa_pkg;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned QVAL_W   = 2 * WORD_W;
  localparam int unsigned SHIFT_W  = 8;
  localparam int unsigned CHK_W    = 8;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned IN_DATA_W  = 4 * WORD_W + SHIFT_W;
  localparam int unsigned OUT_USED_W = 2 * WORD_W + 1 + CHK_W;
  localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_LESS      = 3'd0,
    CMD_EQUAL     = 3'd1,
    CMD_ADD_SAT   = 3'd2,
    CMD_ADD_WRAP  = 3'd3,
    CMD_SUB_SAT   = 3'd4,
    CMD_SOFT_THR  = 3'd5,
    CMD_SHIFT_R   = 3'd6,
    CMD_CHECKSUM  = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [WORD_W-1:0]    a_int;
    logic [WORD_W-1:0]    a_frac;
    logic [WORD_W-1:0]    b_int;
    logic [WORD_W-1:0]    b_frac;
    logic [SHIFT_W-1:0]   shift_count;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0]    res_int;
    logic [WORD_W-1:0]    res_frac;
    logic                 flag;
    logic [CHK_W-1:0]     check_byte;
  } result_t;

endpackage

// File: design/q64sa_alu.sv
// Single-pass datapath of the 64.64 saturating ALU.
// Computes one result word from one operand word; purely combinational.
// Depends on q64sa_pkg.
module q64sa_alu
  import q64sa_pkg::*;
(
  input  item_t   item,
  output result_t res
);

  logic [QVAL_W-1:0] a_q;
  logic [QVAL_W-1:0] b_q;
  logic [QVAL_W:0]   sum;
  logic [QVAL_W:0]   diff;
  logic              a_lt_b;
  logic              a_eq_b;
  logic              b_lt_a;
  logic [QVAL_W-1:0] shifted;
  logic [10:0]       chk_sum;

  assign a_q    = {item.a_int, item.a_frac};
  assign b_q    = {item.b_int, item.b_frac};
  assign sum    = {1'b0, a_q} + {1'b0, b_q};
  assign diff   = {1'b0, a_q} - {1'b0, b_q};
  assign a_lt_b = diff[QVAL_W];
  assign a_eq_b = (a_q == b_q);
  assign b_lt_a = !a_lt_b && !a_eq_b;
  assign shifted = (item.shift_count[SHIFT_W-1:6] == 2'b00)
                   ? (a_q >> item.shift_count[5:0]) : '0;
  assign chk_sum = 11'd2 * {3'b000, item.a_int[7:0]}
                 + 11'd3 * {3'b000, item.a_int[39:32]}
                 + 11'd4 * {3'b000, item.a_frac[7:0]}
                 + 11'd5 * {3'b000, item.a_frac[39:32]};

  always_comb begin
    res = '0;
    case (item.cmd)
      CMD_LESS: begin
        res.flag = a_lt_b;
      end
      CMD_EQUAL: begin
        res.flag = a_eq_b;
      end
      CMD_ADD_SAT: begin
        {res.res_int, res.res_frac} = sum[QVAL_W] ? '1 : sum[QVAL_W-1:0];
      end
      CMD_ADD_WRAP: begin
        {res.res_int, res.res_frac} = sum[QVAL_W-1:0];
      end
      CMD_SUB_SAT: begin
        {res.res_int, res.res_frac} = a_lt_b ? '0 : diff[QVAL_W-1:0];
      end
      CMD_SOFT_THR: begin
        {res.res_int, res.res_frac} = b_lt_a ? diff[QVAL_W-1:0] : '0;
      end
      CMD_SHIFT_R: begin
        {res.res_int, res.res_frac} = shifted;
      end
      CMD_CHECKSUM: begin
        res.check_byte = chk_sum[CHK_W-1:0];
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// File: design/q64_64_saturating_alu_top.sv
// Top level of the unsigned 64.64 saturating ALU with stream ports.
// Registers the operand word, runs the datapath and registers the result word.
// Depends on q64sa_pkg and q64sa_alu.
//
// Takes one word per clock while in_tready is high and returns one result word
// per accepted word, in order. A word passes an input register, the ALU datapath
// (128-bit add, subtract and barrel shift) and an output register before
// out_tvalid rises, and the sustained rate is one word per cycle while
// out_tready stays high. Backpressure on the output holds the result register;
// the input register still takes one word while it is empty, then in_tready drops.
module q64_64_saturating_alu_top
  import q64sa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [63:0] a_int, [127:64] a_frac, [191:128] b_int, [255:192] b_frac,
  // [263:256] shift_count
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] cmd
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [63:0] res_int, [127:64] res_frac, [128] flag, [136:129] check_byte,
  // [143:137] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic    s1_v_r;
  logic    s1_v_nxt;
  item_t   s1_item_r;
  logic    out_v_r;
  logic    out_v_nxt;
  result_t out_res_r;
  result_t alu_res;
  logic    out_adv;
  logic    s1_adv;

  assign out_adv   = !out_v_r || out_tready;
  assign s1_adv    = !s1_v_r || out_adv;
  assign in_tready = s1_adv;

  assign s1_v_nxt  = s1_adv ? in_tvalid : s1_v_r;
  assign out_v_nxt = out_adv ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && s1_adv) begin
      s1_item_r.cmd         <= cmd_t'(in_tuser);
      s1_item_r.a_int       <= in_tdata[63:0];
      s1_item_r.a_frac      <= in_tdata[127:64];
      s1_item_r.b_int       <= in_tdata[191:128];
      s1_item_r.b_frac      <= in_tdata[255:192];
      s1_item_r.shift_count <= in_tdata[263:256];
    end
    if (s1_v_r && out_adv) begin
      out_res_r <= alu_res;
    end
  end

  q64sa_alu u_alu (
    .item (s1_item_r),
    .res  (alu_res)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_res_r.check_byte, out_res_r.flag,
                       out_res_r.res_frac, out_res_r.res_int};

endmodule
